@@ rtl/core/lbce_pkg.sv @@
package lbce_pkg;

  localparam int NUM_SLOTS_DEF     = 8;
  localparam int PINS_PER_SLOT_DEF = 8;
  localparam int NUM_PINS_DEF      = 64;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [63:0] ALLOWED_MASK_RST  = 64'd13133213748;
  localparam logic [15:0] DEF_BLINK_RST     = 16'd500;
  localparam logic [15:0] DEF_CHASE_RST     = 16'd200;

  localparam logic [1:0] CFG_ALLOWED_MASK = 2'd0;
  localparam logic [1:0] CFG_DEF_BLINK    = 2'd1;
  localparam logic [1:0] CFG_DEF_CHASE    = 2'd2;

  localparam logic [2:0] CMD_SET   = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_BLINK = 3'd2;
  localparam logic [2:0] CMD_CHASE = 3'd3;
  localparam logic [2:0] CMD_STOP  = 3'd4;
  localparam logic [2:0] CMD_TICK  = 3'd5;

  localparam logic [1:0] DRV_LOW    = 2'd0;
  localparam logic [1:0] DRV_HIGH   = 2'd1;
  localparam logic [1:0] DRV_TOGGLE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BUSY   = 2'd1;
  localparam logic [1:0] ST_DENIED = 2'd2;
  localparam logic [1:0] ST_STAGED = 2'd3;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_BLINK = 2'd1,
    MODE_CHASE = 2'd2
  } slot_mode_t;

  typedef enum logic [2:0] {
    OP_SET,
    OP_READ,
    OP_BLINK,
    OP_CHASE,
    OP_STOP,
    OP_TICK,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  pin;
    logic [1:0]  lvl;
    logic        every;
    logic        ok;
    logic [15:0] ticks;
    logic [15:0] rep;
    logic        last;
  } req_t;

endpackage

@@ rtl/core/lbce_front.sv @@
module lbce_front #(
  parameter int NUM_PINS = lbce_pkg::NUM_PINS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          cmd,
  input  logic [5:0]          pin,
  input  logic [1:0]          drive_level,
  input  logic                every_pin,
  input  logic [15:0]         interval,
  input  logic [15:0]         repeat_count,
  input  logic                last_pin,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output logic                q_valid,
  output lbce_pkg::req_t      q_req,
  input  logic                q_pop,
  output logic [63:0]         mask_eff
);

  localparam logic [63:0] RANGE = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - NUM_PINS);

  logic [63:0] allowed_mask;
  logic [15:0] def_blink;
  logic [15:0] def_chase;

  lbce_pkg::req_t req;
  lbce_pkg::req_t q [lbce_pkg::QUEUE_DEPTH];
  logic           wp;
  logic           rp;
  logic [1:0]     cnt;
  logic [15:0]    dflt;
  logic [15:0]    pick;
  logic           push;

  assign cfg_ready = 1'b1;
  assign mask_eff  = allowed_mask & RANGE;

  always_ff @(posedge clk) begin
    if (rst) begin
      allowed_mask <= lbce_pkg::ALLOWED_MASK_RST;
      def_blink    <= lbce_pkg::DEF_BLINK_RST;
      def_chase    <= lbce_pkg::DEF_CHASE_RST;
    end else if (cfg_valid) begin
      if (cfg_index == lbce_pkg::CFG_ALLOWED_MASK) allowed_mask <= cfg_data;
      if (cfg_index == lbce_pkg::CFG_DEF_BLINK)    def_blink    <= cfg_data[15:0];
      if (cfg_index == lbce_pkg::CFG_DEF_CHASE)    def_chase    <= cfg_data[15:0];
    end
  end

  always_comb begin
    unique case (cmd)
      lbce_pkg::CMD_SET:   req.op = lbce_pkg::OP_SET;
      lbce_pkg::CMD_READ:  req.op = lbce_pkg::OP_READ;
      lbce_pkg::CMD_BLINK: req.op = lbce_pkg::OP_BLINK;
      lbce_pkg::CMD_CHASE: req.op = lbce_pkg::OP_CHASE;
      lbce_pkg::CMD_STOP:  req.op = lbce_pkg::OP_STOP;
      lbce_pkg::CMD_TICK:  req.op = lbce_pkg::OP_TICK;
      default:             req.op = lbce_pkg::OP_BAD;
    endcase
    dflt = (cmd == lbce_pkg::CMD_CHASE) ? def_chase : def_blink;
    pick = (interval != 16'd0) ? interval : dflt;
    if (pick == 16'd0) pick = 16'd1;
    req.pin   = pin;
    req.lvl   = drive_level;
    req.every = every_pin;
    req.ok    = mask_eff[pin];
    req.ticks = pick;
    req.rep   = repeat_count;
    req.last  = last_pin;
  end

  assign in_ready = (cnt != 2'(lbce_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt != 2'd0);
  assign q_req    = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      if (push && !q_pop) cnt <= cnt + 2'd1;
      else if (!push && q_pop) cnt <= cnt - 2'd1;
    end
  end

endmodule

@@ rtl/core/lbce_back.sv @@
module lbce_back #(
  parameter int NUM_SLOTS     = lbce_pkg::NUM_SLOTS_DEF,
  parameter int PINS_PER_SLOT = lbce_pkg::PINS_PER_SLOT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  lbce_pkg::req_t q_req,
  output logic           q_pop,
  input  logic [63:0]    mask_eff,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     status,
  output logic           read_level,
  output logic [63:0]    pin_levels
);

  localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SCW   = $clog2(NUM_SLOTS + 1);
  localparam int ICW   = $clog2(PINS_PER_SLOT + 1);
  localparam int PW    = (PINS_PER_SLOT > 1) ? $clog2(PINS_PER_SLOT) : 1;
  localparam int DEPTH = NUM_SLOTS * PINS_PER_SLOT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_DISP    = 15'b000000000000010,
    S_OWN_A   = 15'b000000000000100,
    S_OWN_C   = 15'b000000000001000,
    S_HALT_A  = 15'b000000000010000,
    S_HALT_D  = 15'b000000000100000,
    S_HALLA   = 15'b000000001000000,
    S_POST    = 15'b000000010000000,
    S_CH_LOOP = 15'b000000100000000,
    S_CH_WR   = 15'b000001000000000,
    S_TK      = 15'b000010000000000,
    S_TK_FIRE = 15'b000100000000000,
    S_TK_RD   = 15'b001000000000000,
    S_TK_ON   = 15'b010000000000000,
    S_DONE    = 15'b100000000000000
  } state_t;

  function automatic logic [AW-1:0] maddr(input logic [SW-1:0] s, input logic [ICW-1:0] i);
    return AW'(int'(s) * PINS_PER_SLOT + int'(i));
  endfunction

  state_t state;
  state_t own_ret;
  state_t halt_ret;

  lbce_pkg::req_t it;
  logic [1:0]     st;
  logic           rd;
  logic           ph;
  logic [63:0]    levels;

  lbce_pkg::slot_mode_t mode [NUM_SLOTS];
  logic [ICW-1:0]       total [NUM_SLOTS];
  logic [ICW-1:0]       pos   [NUM_SLOTS];
  logic                 blink [NUM_SLOTS];
  logic [15:0]          cdone [NUM_SLOTS];
  logic [15:0]          limit [NUM_SLOTS];
  logic [15:0]          reload[NUM_SLOTS];
  logic [15:0]          cd    [NUM_SLOTS];

  logic [5:0]     stg [PINS_PER_SLOT];
  logic [ICW-1:0] stg_total;

  logic [5:0]     mem [DEPTH];
  logic [5:0]     rdata;
  logic [AW-1:0]  raddr;
  logic [AW-1:0]  waddr;
  logic [5:0]     wdata;
  logic           we;

  logic [SCW-1:0] os;
  logic [ICW-1:0] oi;
  logic [5:0]     target;
  logic           own_found;
  logic [SW-1:0]  own_slot;
  logic [SW-1:0]  hs;
  logic [ICW-1:0] hi;
  logic [SCW-1:0] ha;
  logic [ICW-1:0] ci;
  logic [ICW-1:0] cn;
  logic [SW-1:0]  cs;
  logic [SCW-1:0] ts;
  logic [SW-1:0]  tsi;
  logic [SW-1:0]  osi;
  logic           free_found;
  logic [SW-1:0]  free_s;
  logic           out_load;

  assign tsi = ts[SW-1:0];
  assign osi = os[SW-1:0];
  assign q_pop = (state == S_IDLE) && q_valid;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    free_found = 1'b0;
    free_s     = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (mode[s] == lbce_pkg::MODE_IDLE) begin
        free_found = 1'b1;
        free_s     = SW'(s);
      end
    end
  end

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    unique case (state)
      S_OWN_A:  raddr = maddr(osi, oi);
      S_HALT_A: raddr = maddr(hs, hi);
      S_TK:     raddr = maddr(tsi, (mode[tsi] == lbce_pkg::MODE_BLINK) ? '0 : pos[tsi]);
      S_TK_RD:  raddr = maddr(tsi, pos[tsi]);
      S_CH_WR: begin
        if (ci != cn) begin
          we    = 1'b1;
          waddr = maddr(cs, ci);
          wdata = stg[ci[PW-1:0]];
        end
      end
      S_POST: begin
        if (it.op == lbce_pkg::OP_BLINK && ph) begin
          we    = 1'b1;
          waddr = maddr(cs, '0);
          wdata = it.pin;
        end
      end
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      status     <= st;
      read_level <= rd;
      pin_levels <= levels;
    end
  end

  always_ff @(posedge clk) begin : seq
    logic [15:0]    dn;
    logic [ICW-1:0] np;
    logic           nb;
    logic [SW-1:0]  sel;
    dn  = '0;
    np  = '0;
    nb  = 1'b0;
    sel = '0;
    if (rst) begin
      state     <= S_IDLE;
      own_ret   <= S_IDLE;
      halt_ret  <= S_IDLE;
      levels    <= '0;
      stg_total <= '0;
      ph        <= 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        mode[s]   <= lbce_pkg::MODE_IDLE;
        total[s]  <= '0;
        pos[s]    <= '0;
        blink[s]  <= 1'b0;
        cdone[s]  <= '0;
        limit[s]  <= '0;
        reload[s] <= '0;
        cd[s]     <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            it    <= q_req;
            st    <= lbce_pkg::ST_OK;
            rd    <= 1'b0;
            ph    <= 1'b0;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          target    <= it.pin;
          os        <= '0;
          oi        <= '0;
          own_found <= 1'b0;
          own_ret   <= S_POST;
          ha        <= '0;
          unique case (it.op)
            lbce_pkg::OP_SET: begin
              if (it.every) begin
                if (it.lvl == lbce_pkg::DRV_TOGGLE) begin
                  levels <= levels ^ mask_eff;
                  state  <= S_DONE;
                end else begin
                  state <= S_HALLA;
                end
              end else if (!it.ok) begin
                st    <= lbce_pkg::ST_DENIED;
                state <= S_DONE;
              end else begin
                state <= S_OWN_A;
              end
            end
            lbce_pkg::OP_READ: begin
              if (!it.ok) st <= lbce_pkg::ST_DENIED;
              else rd <= levels[it.pin];
              state <= S_DONE;
            end
            lbce_pkg::OP_BLINK: begin
              if (it.every) begin
                st    <= lbce_pkg::ST_BUSY;
                state <= S_DONE;
              end else if (!it.ok) begin
                st    <= lbce_pkg::ST_DENIED;
                state <= S_DONE;
              end else begin
                state <= S_OWN_A;
              end
            end
            lbce_pkg::OP_CHASE: begin
              if (!it.ok) begin
                st        <= lbce_pkg::ST_DENIED;
                stg_total <= '0;
                state     <= S_DONE;
              end else if (stg_total >= ICW'(PINS_PER_SLOT)) begin
                st        <= lbce_pkg::ST_BUSY;
                stg_total <= '0;
                state     <= S_DONE;
              end else begin
                stg[stg_total[PW-1:0]] <= it.pin;
                if (!it.last) begin
                  stg_total <= stg_total + 1'b1;
                  st        <= lbce_pkg::ST_STAGED;
                  state     <= S_DONE;
                end else begin
                  stg_total <= '0;
                  cn        <= stg_total + 1'b1;
                  ci        <= '0;
                  state     <= S_CH_LOOP;
                end
              end
            end
            lbce_pkg::OP_STOP: begin
              if (it.every) begin
                state <= S_HALLA;
              end else if (!it.ok) begin
                st    <= lbce_pkg::ST_DENIED;
                state <= S_DONE;
              end else begin
                state <= S_OWN_A;
              end
            end
            lbce_pkg::OP_TICK: begin
              ts    <= '0;
              state <= S_TK;
            end
            default: begin
              st    <= lbce_pkg::ST_BUSY;
              state <= S_DONE;
            end
          endcase
        end
        S_OWN_A: begin
          if (os == SCW'(NUM_SLOTS)) begin
            state <= own_ret;
          end else if (mode[osi] == lbce_pkg::MODE_IDLE || oi >= total[osi]) begin
            os <= os + 1'b1;
            oi <= '0;
          end else begin
            state <= S_OWN_C;
          end
        end
        S_OWN_C: begin
          if (rdata == target) begin
            own_found <= 1'b1;
            own_slot  <= osi;
            state     <= own_ret;
          end else begin
            oi    <= oi + 1'b1;
            state <= S_OWN_A;
          end
        end
        S_HALT_A: begin
          if (hi >= total[hs]) begin
            mode[hs]  <= lbce_pkg::MODE_IDLE;
            total[hs] <= '0;
            state     <= halt_ret;
          end else begin
            state <= S_HALT_D;
          end
        end
        S_HALT_D: begin
          levels[rdata] <= 1'b0;
          hi            <= hi + 1'b1;
          state         <= S_HALT_A;
        end
        S_HALLA: begin
          if (ha == SCW'(NUM_SLOTS)) begin
            state <= S_POST;
          end else begin
            ha <= ha + 1'b1;
            if (mode[ha[SW-1:0]] != lbce_pkg::MODE_IDLE) begin
              hs       <= ha[SW-1:0];
              hi       <= '0;
              halt_ret <= S_HALLA;
              state    <= S_HALT_A;
            end
          end
        end
        S_POST: begin
          unique case (it.op)
            lbce_pkg::OP_SET: begin
              if (it.every) begin
                if (it.lvl == lbce_pkg::DRV_HIGH) levels <= levels | mask_eff;
                else levels <= levels & ~mask_eff;
                state <= S_DONE;
              end else if (own_found && !ph) begin
                hs       <= own_slot;
                hi       <= '0;
                halt_ret <= S_POST;
                ph       <= 1'b1;
                state    <= S_HALT_A;
              end else begin
                if (it.lvl == lbce_pkg::DRV_TOGGLE) levels[it.pin] <= ~levels[it.pin];
                else levels[it.pin] <= (it.lvl == lbce_pkg::DRV_HIGH);
                state <= S_DONE;
              end
            end
            lbce_pkg::OP_BLINK: begin
              if (!ph) begin
                if (!own_found && !free_found) begin
                  st    <= lbce_pkg::ST_BUSY;
                  state <= S_DONE;
                end else begin
                  sel      = own_found ? own_slot : free_s;
                  cs       <= sel;
                  hs       <= sel;
                  hi       <= '0;
                  halt_ret <= S_POST;
                  ph       <= 1'b1;
                  state    <= S_HALT_A;
                end
              end else begin
                mode[cs]       <= lbce_pkg::MODE_BLINK;
                total[cs]      <= ICW'(1);
                pos[cs]        <= '0;
                blink[cs]      <= 1'b0;
                cdone[cs]      <= '0;
                limit[cs]      <= it.rep;
                reload[cs]     <= it.ticks;
                cd[cs]         <= it.ticks;
                levels[it.pin] <= 1'b0;
                state          <= S_DONE;
              end
            end
            lbce_pkg::OP_CHASE: begin
              ci <= ci + 1'b1;
              if (own_found) begin
                hs       <= own_slot;
                hi       <= '0;
                halt_ret <= S_CH_LOOP;
                state    <= S_HALT_A;
              end else begin
                state <= S_CH_LOOP;
              end
            end
            lbce_pkg::OP_STOP: begin
              if (!it.every && own_found && !ph) begin
                hs       <= own_slot;
                hi       <= '0;
                halt_ret <= S_POST;
                ph       <= 1'b1;
                state    <= S_HALT_A;
              end else begin
                state <= S_DONE;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_CH_LOOP: begin
          if (ci == cn) begin
            if (!free_found) begin
              st    <= lbce_pkg::ST_BUSY;
              state <= S_DONE;
            end else begin
              cs    <= free_s;
              ci    <= '0;
              state <= S_CH_WR;
            end
          end else begin
            target    <= stg[ci[PW-1:0]];
            os        <= '0;
            oi        <= '0;
            own_found <= 1'b0;
            own_ret   <= S_POST;
            state     <= S_OWN_A;
          end
        end
        S_CH_WR: begin
          if (ci == cn) begin
            mode[cs]      <= lbce_pkg::MODE_CHASE;
            total[cs]     <= cn;
            pos[cs]       <= '0;
            blink[cs]     <= 1'b0;
            cdone[cs]     <= '0;
            limit[cs]     <= it.rep;
            reload[cs]    <= it.ticks;
            cd[cs]        <= it.ticks;
            levels[stg[0]] <= 1'b1;
            state         <= S_DONE;
          end else begin
            levels[stg[ci[PW-1:0]]] <= 1'b0;
            ci                      <= ci + 1'b1;
          end
        end
        S_TK: begin
          if (ts == SCW'(NUM_SLOTS)) begin
            state <= S_DONE;
          end else if (mode[tsi] == lbce_pkg::MODE_IDLE) begin
            ts <= ts + 1'b1;
          end else if (cd[tsi] <= 16'd1) begin
            cd[tsi] <= (reload[tsi] != 16'd0) ? reload[tsi] : 16'd1;
            state   <= S_TK_FIRE;
          end else begin
            cd[tsi] <= cd[tsi] - 16'd1;
            ts      <= ts + 1'b1;
          end
        end
        S_TK_FIRE: begin
          dn = cdone[tsi] + 16'd1;
          if (mode[tsi] == lbce_pkg::MODE_BLINK) begin
            nb            = ~blink[tsi];
            blink[tsi]    <= nb;
            levels[rdata] <= nb;
            ts            <= ts + 1'b1;
            if (!nb) cdone[tsi] <= dn;
            if (!nb && limit[tsi] != 16'd0 && dn >= limit[tsi]) begin
              hs       <= tsi;
              hi       <= '0;
              halt_ret <= S_TK;
              state    <= S_HALT_A;
            end else begin
              state <= S_TK;
            end
          end else begin
            levels[rdata] <= 1'b0;
            np = pos[tsi] + 1'b1;
            if (np >= total[tsi]) begin
              np         = '0;
              cdone[tsi] <= dn;
            end
            pos[tsi] <= np;
            if (np == '0 && limit[tsi] != 16'd0 && dn >= limit[tsi]) begin
              hs       <= tsi;
              hi       <= '0;
              halt_ret <= S_TK;
              ts       <= ts + 1'b1;
              state    <= S_HALT_A;
            end else begin
              state <= S_TK_RD;
            end
          end
        end
        S_TK_RD: begin
          state <= S_TK_ON;
        end
        S_TK_ON: begin
          levels[rdata] <= 1'b1;
          ts            <= ts + 1'b1;
          state         <= S_TK;
        end
        S_DONE: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/multi_slot_led_blink_chase_engine_core.sv @@
// Pin blink and chase engine with eight animation slots.
// Requests arrive on in_valid/in_ready (cmd, pin, drive_level, every_pin,
// interval, repeat_count, last_pin); each gives exactly one result on
// out_valid/out_ready (status, read_level, pin_levels), in request order.
// Registers are written on cfg_valid/cfg_ready (cfg_index, cfg_data); write
// them only while no request is in flight. cfg_ready is always high.
// A two-entry queue decouples intake from the execution sequencer, so up to
// two requests are taken while the sequencer is busy.
// Set-all-toggle, read and denials go from dispatch straight to the result
// stage; owner lookups walk the slot pin lists held in one single-port-read
// RAM entry by entry, halting a slot walks its pins, and a tick visits each
// active slot plus any halt. One request at a time. The RAM read port paces
// these walks.
// Reset (rst, synchronous) clears all pins low, idles every slot, empties the
// queue and restores the register defaults. No clearing pass is needed.
// If the receiver stalls, one result waits in the output register, the
// sequencer finishes the next request and then waits, and intake stops once
// the queue is full.
module multi_slot_led_blink_chase_engine_core #(
  parameter int NUM_SLOTS     = lbce_pkg::NUM_SLOTS_DEF,
  parameter int PINS_PER_SLOT = lbce_pkg::PINS_PER_SLOT_DEF,
  parameter int NUM_PINS      = lbce_pkg::NUM_PINS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [5:0]  pin,
  input  logic [1:0]  drive_level,
  input  logic        every_pin,
  input  logic [15:0] interval,
  input  logic [15:0] repeat_count,
  input  logic        last_pin,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        read_level,
  output logic [63:0] pin_levels,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic           q_valid;
  lbce_pkg::req_t q_req;
  logic           q_pop;
  logic [63:0]    mask_eff;

  lbce_front #(
    .NUM_PINS(NUM_PINS)
  ) u_front (
    .clk,
    .rst,
    .in_valid,
    .in_ready,
    .cmd,
    .pin,
    .drive_level,
    .every_pin,
    .interval,
    .repeat_count,
    .last_pin,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data,
    .q_valid,
    .q_req,
    .q_pop,
    .mask_eff
  );

  lbce_back #(
    .NUM_SLOTS(NUM_SLOTS),
    .PINS_PER_SLOT(PINS_PER_SLOT)
  ) u_back (
    .clk,
    .rst,
    .q_valid,
    .q_req,
    .q_pop,
    .mask_eff,
    .out_valid,
    .out_ready,
    .status,
    .read_level,
    .pin_levels
  );

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 8;
  localparam int NPPS  = 8;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int N_RANDOM = 1420;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] cmd = '0;
  logic [5:0] pin = '0;
  logic [1:0] drive_level = '0;
  logic every_pin = 1'b0;
  logic [15:0] interval = '0;
  logic [15:0] repeat_count = '0;
  logic last_pin = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic read_level;
  logic [63:0] pin_levels;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multi_slot_led_blink_chase_engine_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .pin(pin), .drive_level(drive_level), .every_pin(every_pin),
    .interval(interval), .repeat_count(repeat_count), .last_pin(last_pin),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .read_level(read_level), .pin_levels(pin_levels),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    logic [2:0]  c;
    logic [5:0]  p;
    logic [1:0]  lv;
    logic        ev;
    logic [15:0] iv;
    logic [15:0] rp;
    logic        lp;
  } cmd_req_t;

  typedef struct {
    logic [1:0]  st;
    logic        rd;
    logic [63:0] lv;
  } pin_reply_t;

  // engine shadow
  logic [63:0] m_mask;
  logic [15:0] m_dblink, m_dchase;
  logic [63:0] m_levels;
  lbce_pkg::slot_mode_t m_mode [NSLOT];
  logic [5:0]  m_list [NSLOT][NPPS];
  int          m_total [NSLOT];
  int          m_pos [NSLOT];
  logic        m_blv [NSLOT];
  logic [15:0] m_done [NSLOT], m_limit [NSLOT], m_reload [NSLOT], m_count [NSLOT];
  logic [5:0]  m_staged [NPPS];
  int          m_nstaged;

  pin_reply_t reply_q[$];
  int mismatches = 0;
  int replies_seen = 0;
  int idle_cycles = 0;
  int n_tick = 0, n_chase = 0, n_blink = 0;

  task automatic shadow_reset();
    m_mask = lbce_pkg::ALLOWED_MASK_RST;
    m_dblink = lbce_pkg::DEF_BLINK_RST;
    m_dchase = lbce_pkg::DEF_CHASE_RST;
    m_levels = '0;
    for (int s = 0; s < NSLOT; s++) begin
      m_mode[s] = lbce_pkg::MODE_IDLE;
      m_total[s] = 0;
      m_pos[s] = 0;
      m_blv[s] = 1'b0;
      m_done[s] = '0;
      m_limit[s] = '0;
      m_reload[s] = '0;
      m_count[s] = '0;
    end
    m_nstaged = 0;
  endtask

  function automatic bit allowed(logic [5:0] p);
    return m_mask[p];
  endfunction

  task automatic stop_slot(int s);
    for (int i = 0; i < m_total[s] && i < NPPS; i++) m_levels[m_list[s][i]] = 1'b0;
    m_mode[s] = lbce_pkg::MODE_IDLE;
    m_total[s] = 0;
  endtask

  task automatic stop_all_slots();
    for (int s = 0; s < NSLOT; s++) if (m_mode[s] != lbce_pkg::MODE_IDLE) stop_slot(s);
  endtask

  function automatic int owning_slot(logic [5:0] p);
    for (int s = 0; s < NSLOT; s++) begin
      if (m_mode[s] == lbce_pkg::MODE_IDLE) continue;
      for (int i = 0; i < m_total[s] && i < NPPS; i++) if (m_list[s][i] == p) return s;
    end
    return -1;
  endfunction

  function automatic int idle_slot();
    for (int s = 0; s < NSLOT; s++) if (m_mode[s] == lbce_pkg::MODE_IDLE) return s;
    return -1;
  endfunction

  function automatic logic [15:0] step_ticks(logic [15:0] given, logic [15:0] dflt);
    logic [15:0] v;
    v = (given == 0) ? dflt : given;
    return (v == 0) ? 16'd1 : v;
  endfunction

  task automatic advance_slot(int s);
    int p;
    if (m_mode[s] == lbce_pkg::MODE_BLINK) begin
      m_blv[s] = ~m_blv[s];
      m_levels[m_list[s][0]] = m_blv[s];
      if (!m_blv[s]) begin
        m_done[s]++;
        if (m_limit[s] != 0 && m_done[s] >= m_limit[s]) stop_slot(s);
      end
    end else if (m_mode[s] == lbce_pkg::MODE_CHASE) begin
      p = m_pos[s];
      if (p >= NPPS) p = 0;
      m_levels[m_list[s][p]] = 1'b0;
      p++;
      if (p >= m_total[s] || p >= NPPS) begin
        p = 0;
        m_done[s]++;
        if (m_limit[s] != 0 && m_done[s] >= m_limit[s]) begin
          m_pos[s] = 0;
          stop_slot(s);
          return;
        end
      end
      m_pos[s] = p;
      m_levels[m_list[s][p]] = 1'b1;
    end
  endtask

  task automatic start_slot(int s, lbce_pkg::slot_mode_t md, logic [15:0] rp,
                            logic [15:0] tk);
    m_mode[s] = md;
    m_pos[s] = 0;
    m_blv[s] = 1'b0;
    m_done[s] = '0;
    m_limit[s] = rp;
    m_reload[s] = tk;
    m_count[s] = tk;
  endtask

  task automatic predict_reply(cmd_req_t r, output pin_reply_t o);
    int s, n;
    o.st = lbce_pkg::ST_OK;
    o.rd = 1'b0;
    case (r.c)
      lbce_pkg::CMD_SET: begin
        if (r.ev) begin
          if (r.lv == lbce_pkg::DRV_TOGGLE) m_levels ^= m_mask;
          else begin
            stop_all_slots();
            if (r.lv == lbce_pkg::DRV_HIGH) m_levels |= m_mask; else m_levels &= ~m_mask;
          end
        end else if (!allowed(r.p)) o.st = lbce_pkg::ST_DENIED;
        else begin
          s = owning_slot(r.p);
          if (s >= 0) stop_slot(s);
          if (r.lv == lbce_pkg::DRV_TOGGLE) m_levels[r.p] = ~m_levels[r.p];
          else m_levels[r.p] = (r.lv == lbce_pkg::DRV_HIGH);
        end
      end
      lbce_pkg::CMD_READ: begin
        if (!allowed(r.p)) o.st = lbce_pkg::ST_DENIED;
        else o.rd = m_levels[r.p];
      end
      lbce_pkg::CMD_BLINK: begin
        if (r.ev) o.st = lbce_pkg::ST_BUSY;
        else if (!allowed(r.p)) o.st = lbce_pkg::ST_DENIED;
        else begin
          s = owning_slot(r.p);
          if (s < 0) s = idle_slot();
          if (s < 0) o.st = lbce_pkg::ST_BUSY;
          else begin
            stop_slot(s);
            m_list[s][0] = r.p;
            m_total[s] = 1;
            start_slot(s, lbce_pkg::MODE_BLINK, r.rp, step_ticks(r.iv, m_dblink));
            m_levels[r.p] = 1'b0;
          end
        end
      end
      lbce_pkg::CMD_CHASE: begin
        if (!allowed(r.p)) begin
          o.st = lbce_pkg::ST_DENIED;
          m_nstaged = 0;
        end else if (m_nstaged >= NPPS) begin
          o.st = lbce_pkg::ST_BUSY;
          m_nstaged = 0;
        end else begin
          m_staged[m_nstaged++] = r.p;
          if (!r.lp) o.st = lbce_pkg::ST_STAGED;
          else begin
            n = m_nstaged;
            m_nstaged = 0;
            for (int i = 0; i < n; i++) begin
              s = owning_slot(m_staged[i]);
              if (s >= 0) stop_slot(s);
            end
            s = idle_slot();
            if (s < 0) o.st = lbce_pkg::ST_BUSY;
            else begin
              for (int i = 0; i < n; i++) begin
                m_levels[m_staged[i]] = 1'b0;
                m_list[s][i] = m_staged[i];
              end
              m_total[s] = n;
              start_slot(s, lbce_pkg::MODE_CHASE, r.rp, step_ticks(r.iv, m_dchase));
              m_levels[m_list[s][0]] = 1'b1;
            end
          end
        end
      end
      lbce_pkg::CMD_STOP: begin
        if (r.ev) stop_all_slots();
        else if (!allowed(r.p)) o.st = lbce_pkg::ST_DENIED;
        else begin
          s = owning_slot(r.p);
          if (s >= 0) stop_slot(s);
        end
      end
      lbce_pkg::CMD_TICK: begin
        for (int k = 0; k < NSLOT; k++) begin
          if (m_mode[k] == lbce_pkg::MODE_IDLE) continue;
          if (m_count[k] <= 1) begin
            m_count[k] = (m_reload[k] != 0) ? m_reload[k] : 16'd1;
            advance_slot(k);
          end else m_count[k]--;
        end
      end
      default: o.st = lbce_pkg::ST_BUSY;
    endcase
    o.lv = m_levels;
  endtask

  // result checking and watchdog
  always @(posedge clk) begin
    pin_reply_t e;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", idle_cycles);
        $display("TEST FAILED");
        $finish;
      end
      if (out_valid && out_ready) begin
        replies_seen++;
        if (reply_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result status=%0d", status);
        end else begin
          e = reply_q.pop_front();
          if (status !== e.st || read_level !== e.rd || pin_levels !== e.lv) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d: exp st=%0d rd=%0d lv=%h, got st=%0d rd=%0d lv=%h",
                       replies_seen, e.st, e.rd, e.lv, status, read_level, pin_levels);
          end
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int g;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  // returns at the accepting edge; the next send or drain lowers or reloads in_valid
  task automatic send(cmd_req_t r);
    pin_reply_t e;
    int g;
    g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80) :
        ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    @(negedge clk);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    cmd <= r.c; pin <= r.p; drive_level <= r.lv; every_pin <= r.ev;
    interval <= r.iv; repeat_count <= r.rp; last_pin <= r.lp;
    in_valid <= 1'b1;
    predict_reply(r, e);
    reply_q.push_back(e);
    if (r.c == lbce_pkg::CMD_TICK) n_tick++;
    if (r.c == lbce_pkg::CMD_CHASE && r.lp) n_chase++;
    if (r.c == lbce_pkg::CMD_BLINK) n_blink++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == lbce_pkg::CFG_ALLOWED_MASK) m_mask = val;
    else if (idx == lbce_pkg::CFG_DEF_BLINK) m_dblink = val[15:0];
    else if (idx == lbce_pkg::CFG_DEF_CHASE) m_dchase = val[15:0];
    @(negedge clk);
  endtask

  function automatic logic [5:0] pick_pin();
    logic [5:0] p;
    if ($urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
    for (int k = 0; k < 16; k++) begin
      p = 6'($urandom_range(0, 63));
      if (m_mask[p]) return p;
    end
    return p;
  endfunction

  function automatic cmd_req_t rand_req();
    cmd_req_t r;
    int w;
    r.c = lbce_pkg::CMD_TICK; r.p = pick_pin(); r.lv = 2'($urandom_range(0, 3));
    r.ev = ($urandom_range(0, 9) == 0);
    r.iv = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    r.rp = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    r.lp = 1'b0;
    w = $urandom_range(0, 99);
    if (w < 40) r.c = lbce_pkg::CMD_TICK;
    else if (w < 52) r.c = lbce_pkg::CMD_SET;
    else if (w < 60) r.c = lbce_pkg::CMD_READ;
    else if (w < 72) r.c = lbce_pkg::CMD_BLINK;
    else if (w < 92) begin
      r.c = lbce_pkg::CMD_CHASE;
      r.lp = ($urandom_range(0, 2) == 0);
    end else if (w < 97) r.c = lbce_pkg::CMD_STOP;
    else r.c = 3'($urandom_range(6, 7));
    return r;
  endfunction

  cmd_req_t   dir_req [$];
  pin_reply_t dir_exp [$];
  bit         dir_has [$];

  task automatic add_row(logic [2:0] c, logic [5:0] p, logic [1:0] lv, logic ev,
                         logic [15:0] iv, logic [15:0] rp, logic lp,
                         bit has, logic [1:0] st, logic rd, logic [63:0] lvs);
    cmd_req_t r;
    pin_reply_t e;
    r.c = c; r.p = p; r.lv = lv; r.ev = ev; r.iv = iv; r.rp = rp; r.lp = lp;
    e.st = st; e.rd = rd; e.lv = lvs;
    dir_req.push_back(r); dir_exp.push_back(e); dir_has.push_back(has);
  endtask

  initial begin
    cmd_req_t r;
    pin_reply_t e;
    int nrand;
    shadow_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // pin 2 is allowed by the reset mask, pin 0 and 63 are not
    add_row(lbce_pkg::CMD_READ, 6'd2, '0, 1'b0, '0, '0, 1'b0,
            1'b1, lbce_pkg::ST_OK, 1'b0, 64'd0);
    add_row(lbce_pkg::CMD_SET, 6'd0, lbce_pkg::DRV_HIGH, 1'b0, '0, '0, 1'b0,
            1'b1, lbce_pkg::ST_DENIED, 1'b0, 64'd0);
    add_row(lbce_pkg::CMD_READ, 6'd63, '0, 1'b0, '0, '0, 1'b0,
            1'b1, lbce_pkg::ST_DENIED, 1'b0, 64'd0);
    add_row(lbce_pkg::CMD_SET, 6'd2, lbce_pkg::DRV_HIGH, 1'b0, '0, '0, 1'b0,
            1'b1, lbce_pkg::ST_OK, 1'b0, 64'd4);
    add_row(lbce_pkg::CMD_READ, 6'd2, '0, 1'b0, '0, '0, 1'b0,
            1'b1, lbce_pkg::ST_OK, 1'b1, 64'd4);
    add_row(lbce_pkg::CMD_SET, 6'd2, 2'd3, 1'b0, '0, '0, 1'b0,
            1'b1, lbce_pkg::ST_OK, 1'b0, 64'd0);
    add_row(lbce_pkg::CMD_SET, 6'd0, lbce_pkg::DRV_TOGGLE, 1'b1, '0, '0, 1'b0,
            1'b1, lbce_pkg::ST_OK, 1'b0, lbce_pkg::ALLOWED_MASK_RST);
    add_row(lbce_pkg::CMD_SET, 6'd0, lbce_pkg::DRV_LOW, 1'b1, '0, '0, 1'b0,
            1'b1, lbce_pkg::ST_OK, 1'b0, 64'd0);
    add_row(3'd6, 6'd2, '0, 1'b0, '0, '0, 1'b0,
            1'b1, lbce_pkg::ST_BUSY, 1'b0, 64'd0);
    add_row(3'd7, 6'd63, 2'd3, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1,
            1'b1, lbce_pkg::ST_BUSY, 1'b0, 64'd0);
    add_row(lbce_pkg::CMD_BLINK, 6'd2, '0, 1'b1, '0, '0, 1'b0,
            1'b1, lbce_pkg::ST_BUSY, 1'b0, 64'd0);
    add_row(lbce_pkg::CMD_BLINK, 6'd2, '0, 1'b0, 16'd1, 16'd2, 1'b0,
            1'b0, '0, 1'b0, '0);
    add_row(lbce_pkg::CMD_TICK, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0);
    add_row(lbce_pkg::CMD_TICK, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0);
    add_row(lbce_pkg::CMD_CHASE, 6'd4, '0, 1'b0, '0, '0, 1'b0,
            1'b1, lbce_pkg::ST_STAGED, 1'b0, 64'd0);
    add_row(lbce_pkg::CMD_CHASE, 6'd5, '0, 1'b0, 16'd0, 16'd0, 1'b1,
            1'b0, '0, 1'b0, '0);
    add_row(lbce_pkg::CMD_TICK, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0);
    add_row(lbce_pkg::CMD_CHASE, 6'd0, '0, 1'b0, '0, '0, 1'b1, 1'b0, '0, 1'b0, '0);
    add_row(lbce_pkg::CMD_SET, 6'd4, lbce_pkg::DRV_TOGGLE, 1'b0, '0, '0, 1'b0,
            1'b0, '0, 1'b0, '0);
    add_row(lbce_pkg::CMD_BLINK, 6'd9, '0, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0,
            1'b0, '0, 1'b0, '0);
    add_row(lbce_pkg::CMD_STOP, 6'd9, '0, 1'b0, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0);
    add_row(lbce_pkg::CMD_STOP, 6'd0, '0, 1'b1, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0);
    // pin 4 was set by hand and is owned by no slot, so it stays high
    add_row(lbce_pkg::CMD_STOP, 6'd63, '0, 1'b0, '0, '0, 1'b0,
            1'b1, lbce_pkg::ST_DENIED, 1'b0, 64'h10);

    for (int i = 0; i < dir_req.size(); i++) begin
      send(dir_req[i]);
      if (dir_has[i]) begin
        e = reply_q[reply_q.size() - 1];
        if (e.st !== dir_exp[i].st || e.rd !== dir_exp[i].rd || e.lv !== dir_exp[i].lv)
        begin
          mismatches++;
          $display("row %0d: model disagrees with typed expectation", i);
        end
        reply_q[reply_q.size() - 1] = dir_exp[i];
      end
    end
    drain();

    // every slot busy, then overlong chase list
    write_reg(lbce_pkg::CFG_ALLOWED_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(lbce_pkg::CFG_DEF_BLINK, 64'd0);
    write_reg(lbce_pkg::CFG_DEF_CHASE, 64'd1);
    for (int s = 0; s < 9; s++) begin
      r = '{lbce_pkg::CMD_BLINK, 6'(s * 3), '0, 1'b0, '0, '0, 1'b0};
      send(r);
    end
    for (int i = 0; i < 10; i++) begin
      r = '{lbce_pkg::CMD_CHASE, 6'(40 + i), '0, 1'b0, '0, '0, 1'b0};
      send(r);
    end
    for (int i = 0; i < 3; i++) begin
      r = '{lbce_pkg::CMD_CHASE, 6'(50 + i), '0, 1'b0, '0, 16'd1, (i == 2)};
      send(r);
    end
    r = '{lbce_pkg::CMD_SET, 6'd0, lbce_pkg::DRV_HIGH, 1'b1, '0, '0, 1'b0};
    send(r);
    // wait for all outstanding results before continuing
    drain();

    nrand = 0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(lbce_pkg::CFG_DEF_BLINK, 64'd2);
          write_reg(lbce_pkg::CFG_DEF_CHASE, 64'd3);
        end
        1: begin
          write_reg(lbce_pkg::CFG_ALLOWED_MASK, {$urandom, $urandom});
          write_reg(lbce_pkg::CFG_DEF_BLINK, 64'hFFFF);
          write_reg(lbce_pkg::CFG_DEF_CHASE, 64'd0);
        end
        2: write_reg(lbce_pkg::CFG_ALLOWED_MASK, 64'd0);
        3: begin
          write_reg(lbce_pkg::CFG_ALLOWED_MASK, 64'h0000_00FF_0000_FF0F);
          write_reg(lbce_pkg::CFG_DEF_BLINK, 64'd1);
          write_reg(lbce_pkg::CFG_DEF_CHASE, 64'hFFFF);
        end
        default: begin
          write_reg(lbce_pkg::CFG_ALLOWED_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(lbce_pkg::CFG_DEF_BLINK, 64'd1);
          write_reg(lbce_pkg::CFG_DEF_CHASE, 64'd2);
        end
      endcase
      for (int i = 0; i < (ph == 2 ? 60 : (N_RANDOM - 60) / 4); i++) begin
        send(rand_req());
        nrand++;
      end
      drain();
    end

    $display("ran %0d random and %0d directed requests: %0d ticks, %0d blinks, %0d chases",
             nrand, dir_req.size(), n_tick, n_blink, n_chase);
    $display("checked %0d results, %0d mismatches", replies_seen, mismatches);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/lbce_pkg.sv
rtl/core/lbce_front.sv
rtl/core/lbce_back.sv
rtl/core/multi_slot_led_blink_chase_engine_core.sv
sim/tb_top.sv
